// ===== rtl/core/plbbc_pkg.sv =====
// Shared types and constants for the pinned LRU byte-budget cache.
package plbbc_pkg;

	localparam int DEF_ENTRIES  = 64;
	localparam int DEF_MAX_SIZE = 1024;

	localparam int BUDGET_W = 18;
	localparam int COUNT_W  = 7;
	localparam int SIZE_IN_W = 11;
	localparam int PIN_W    = 8;
	localparam int STAMP_W  = 64;
	localparam int EVCNT_W  = 6;

	localparam logic [PIN_W-1:0]   PIN_MAX    = 8'd255;
	localparam logic [EVCNT_W-1:0] MAX_EVICTS = 6'd63;

	typedef enum logic [0:0] {
		REG_BUDGET = 1'b0,
		REG_COUNT  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_ACQUIRE = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_FLUSH   = 2'd2,
		ACT_NONE    = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		ST_HIT          = 4'd0,
		ST_LOADED       = 4'd1,
		ST_EVICTED      = 4'd2,
		ST_OVER_BUDGET  = 4'd3,
		ST_BAD_INDEX    = 4'd4,
		ST_UNBALANCED   = 4'd5,
		ST_FLUSH_PINNED = 4'd6,
		ST_PIN_OVERFLOW = 4'd7,
		ST_RELEASED     = 4'd8,
		ST_FLUSHED      = 4'd9
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_FLUSH,
		OP_BADIDX,
		OP_REL,
		OP_HIT,
		OP_LOAD,
		OP_OVER,
		OP_SCAN_CLR,
		OP_SCAN_RD,
		OP_EVICT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic idx_ok;
		logic resident;
		logic fits;
		logic victim_found;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/core/plbbc_ctrl.sv =====
// Sequencer for the cache: decodes each word and steps the victim scan.
module plbbc_ctrl import plbbc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_CHECK  = 6'b000100,
		S_SCAN   = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_EVICT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [EVCNT_W-1:0] evcnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (stat.act == ACT_FLUSH) begin
					if (stat.out_free) begin
						cmd.op  = OP_FLUSH;
						state_d = S_IDLE;
					end
				end else if (stat.act == ACT_NONE) begin
					state_d = S_IDLE;
				end else if (!stat.idx_ok) begin
					if (stat.out_free) begin
						cmd.op  = OP_BADIDX;
						state_d = S_IDLE;
					end
				end else if (stat.act == ACT_RELEASE) begin
					if (stat.out_free) begin
						cmd.op  = OP_REL;
						state_d = S_IDLE;
					end
				end else if (stat.resident) begin
					if (stat.out_free) begin
						cmd.op  = OP_HIT;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (stat.fits) begin
					if (stat.out_free) begin
						cmd.op  = OP_LOAD;
						state_d = S_IDLE;
					end
				end else if (evcnt_q == MAX_EVICTS) begin
					if (stat.out_free) begin
						cmd.op  = OP_OVER;
						state_d = S_IDLE;
					end
				end else begin
					cmd.op  = OP_SCAN_CLR;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.op = OP_SCAN_RD;
				if (stat.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_EVICT;
			end
			S_EVICT: begin
				if (stat.out_free) begin
					if (stat.victim_found) begin
						cmd.op  = OP_EVICT;
						state_d = S_CHECK;
					end else begin
						cmd.op  = OP_OVER;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			evcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DECODE) evcnt_q <= '0;
			else if (cmd.op == OP_EVICT) evcnt_q <= evcnt_q + 1'b1;
		end
	end

endmodule

// ===== rtl/core/plbbc_dp.sv =====
// Entry stores, totals, victim compare and result register of the cache.
module plbbc_dp import plbbc_pkg::*; #(
	parameter int ENTRIES        = DEF_ENTRIES,
	parameter int MAX_SIZE_UNITS = DEF_MAX_SIZE,
	localparam int IDXW = $clog2(ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [BUDGET_W-1:0]  cfg_data,
	input  logic [1:0]           action,
	input  logic [IDXW-1:0]      entry_index,
	input  logic [SIZE_IN_W-1:0] size_units,
	input  logic                 hot,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           status,
	output logic [IDXW-1:0]      slot_index,
	output logic [BUDGET_W-1:0]  resident_units,
	output logic [BUDGET_W-1:0]  pinned_units,
	output logic                 last
);

	localparam int NW  = $clog2(ENTRIES + 1);
	localparam int SZW = $clog2(MAX_SIZE_UNITS + 1);

	logic [BUDGET_W-1:0] budget_q;
	logic [COUNT_W-1:0]  ecount_q;

	act_t                act_q;
	logic [IDXW-1:0]     idx_q;
	logic [SIZE_IN_W-1:0] size_q;
	logic                hot_q;

	logic [ENTRIES-1:0]  resident_q;
	logic [ENTRIES-1:0]  pinned_q;
	logic [STAMP_W-1:0]  use_q;
	logic [BUDGET_W-1:0] rtot_q;
	logic [BUDGET_W-1:0] ptot_q;

	// entry stores; a pin count reads as zero when the pinned bit is clear
	logic [PIN_W-1:0]   pin_mem [ENTRIES];
	logic [STAMP_W-1:0] lu_mem  [ENTRIES];
	logic [SZW:0]       sz_mem  [ENTRIES];

	logic [PIN_W-1:0]   pin_rd_q;
	logic [STAMP_W-1:0] lu_rd_q;
	logic [SZW:0]       sz_rd_q;

	logic [IDXW-1:0]    ptr_q;
	logic [IDXW-1:0]    rd_idx_s1;
	logic               cmp_s1;
	logic               vfound_q;
	logic [IDXW-1:0]    vidx_q;
	logic [STAMP_W-1:0] voldest_q;
	logic [SZW-1:0]     vsize_q;

	logic                out_valid_q;
	logic [3:0]          status_q;
	logic [IDXW-1:0]     slot_q;
	logic [BUDGET_W-1:0] rout_q;
	logic [BUDGET_W-1:0] pout_q;
	logic                last_q;

	logic [NW-1:0]       n_valid;
	logic [SZW-1:0]      size_sat;
	logic [SZW-1:0]      cur_size;
	logic [PIN_W-1:0]    pin_cur;
	logic                rd_en;
	logic [IDXW-1:0]     rd_addr;
	logic                eligible;

	logic                emit;
	status_t             e_status;
	logic [IDXW-1:0]     e_slot;
	logic                e_last;
	logic [BUDGET_W-1:0] rtot_d;
	logic [BUDGET_W-1:0] ptot_d;
	logic                pin_we;
	logic [PIN_W-1:0]    pin_wd;
	logic                stamp_we;

	assign n_valid = (32'(ecount_q) < ENTRIES) ? NW'(ecount_q) : NW'(ENTRIES);
	assign size_sat = (32'(size_q) > MAX_SIZE_UNITS) ? SZW'(MAX_SIZE_UNITS) : SZW'(size_q);
	assign cur_size = sz_rd_q[SZW-1:0];
	assign pin_cur  = pinned_q[idx_q] ? pin_rd_q : '0;
	assign rd_en    = (cmd.op == OP_CAPTURE) || (cmd.op == OP_SCAN_RD);
	assign rd_addr  = (cmd.op == OP_CAPTURE) ? entry_index : ptr_q;
	assign eligible = resident_q[rd_idx_s1] && !pinned_q[rd_idx_s1] && !sz_rd_q[SZW];

	assign stat.act          = act_q;
	assign stat.idx_ok       = NW'(idx_q) < n_valid;
	assign stat.resident     = resident_q[idx_q];
	assign stat.fits = (19'(rtot_q) + 19'(size_sat)) <= 19'(budget_q);
	assign stat.victim_found = vfound_q;
	assign stat.scan_last    = (NW'(ptr_q) + NW'(1)) == n_valid;
	assign stat.out_free     = !out_valid_q || out_ready;

	always_comb begin
		emit     = 1'b0;
		e_status = ST_HIT;
		e_slot   = idx_q;
		e_last   = 1'b1;
		rtot_d   = rtot_q;
		ptot_d   = ptot_q;
		pin_we   = 1'b0;
		pin_wd   = '0;
		stamp_we = 1'b0;
		unique case (cmd.op)
			OP_FLUSH: begin
				emit   = 1'b1;
				e_slot = '0;
				if (|pinned_q) begin
					e_status = ST_FLUSH_PINNED;
				end else begin
					e_status = ST_FLUSHED;
					rtot_d   = '0;
				end
			end
			OP_BADIDX: begin
				emit     = 1'b1;
				e_status = ST_BAD_INDEX;
			end
			OP_REL: begin
				emit = 1'b1;
				if (pin_cur == '0) begin
					e_status = ST_UNBALANCED;
				end else begin
					e_status = ST_RELEASED;
					pin_we   = 1'b1;
					pin_wd   = pin_cur - 1'b1;
					if (pin_cur == PIN_W'(1)) ptot_d = ptot_q - BUDGET_W'(cur_size);
				end
			end
			OP_HIT: begin
				emit = 1'b1;
				if (pin_cur == PIN_MAX) begin
					e_status = ST_PIN_OVERFLOW;
				end else begin
					e_status = ST_HIT;
					pin_we   = 1'b1;
					pin_wd   = pin_cur + 1'b1;
					stamp_we = 1'b1;
					if (pin_cur == '0) ptot_d = ptot_q + BUDGET_W'(cur_size);
				end
			end
			OP_LOAD: begin
				emit     = 1'b1;
				e_status = ST_LOADED;
				pin_we   = 1'b1;
				pin_wd   = PIN_W'(1);
				stamp_we = 1'b1;
				rtot_d   = rtot_q + BUDGET_W'(size_sat);
				ptot_d   = ptot_q + BUDGET_W'(size_sat);
			end
			OP_OVER: begin
				emit     = 1'b1;
				e_status = ST_OVER_BUDGET;
			end
			OP_EVICT: begin
				emit     = 1'b1;
				e_status = ST_EVICTED;
				e_slot   = vidx_q;
				e_last   = 1'b0;
				rtot_d   = rtot_q - BUDGET_W'(vsize_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pin_rd_q <= pin_mem[rd_addr];
			lu_rd_q  <= lu_mem[rd_addr];
			sz_rd_q  <= sz_mem[rd_addr];
		end
		if (pin_we) pin_mem[idx_q] <= pin_wd;
		if (stamp_we) lu_mem[idx_q] <= use_q + 1'b1;
		if (cmd.op == OP_LOAD) sz_mem[idx_q] <= {hot_q, size_sat};
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			act_q  <= act_t'(action);
			idx_q  <= entry_index;
			size_q <= size_units;
			hot_q  <= hot;
		end
		if (rd_en) rd_idx_s1 <= rd_addr;
		if (cmp_s1 && eligible && (!vfound_q || lu_rd_q < voldest_q)) begin
			vidx_q    <= rd_idx_s1;
			voldest_q <= lu_rd_q;
			vsize_q   <= sz_rd_q[SZW-1:0];
		end
		if (emit) begin
			status_q <= e_status;
			slot_q   <= e_slot;
			rout_q   <= rtot_d;
			pout_q   <= ptot_d;
			last_q   <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q    <= '0;
			ecount_q    <= '0;
			resident_q  <= '0;
			pinned_q    <= '0;
			use_q       <= '0;
			rtot_q      <= '0;
			ptot_q      <= '0;
			ptr_q       <= '0;
			cmp_s1      <= 1'b0;
			vfound_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_BUDGET: budget_q <= cfg_data;
					REG_COUNT:  ecount_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			rtot_q <= rtot_d;
			ptot_q <= ptot_d;
			if (stamp_we) use_q <= use_q + 1'b1;
			if (cmd.op == OP_FLUSH && !(|pinned_q)) resident_q <= '0;
			if (cmd.op == OP_LOAD) resident_q[idx_q] <= 1'b1;
			if (cmd.op == OP_EVICT) resident_q[vidx_q] <= 1'b0;
			if (pin_we) pinned_q[idx_q] <= (pin_wd != '0);
			cmp_s1 <= (cmd.op == OP_SCAN_RD);
			if (cmd.op == OP_SCAN_CLR) begin
				ptr_q    <= '0;
				vfound_q <= 1'b0;
			end else if (cmd.op == OP_SCAN_RD) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmp_s1 && eligible) vfound_q <= 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign slot_index     = slot_q;
	assign resident_units = rout_q;
	assign pinned_units   = pout_q;
	assign last           = last_q;

endmodule

// ===== rtl/core/pinned_lru_byte_budget_cache_top.sv =====
// Top level of the pinned LRU byte-budget cache: sequencer plus datapath.
//
// channel  direction  handshake              payload
// in       into block in_valid / in_ready    action, entry_index, size_units, hot
// out      from block out_valid / out_ready  status, slot_index, resident_units,
//                                            pinned_units, last
// cfg      into block cfg_we (no wait)       cfg_index, cfg_data
//
// One word at a time. Hit, release, flush and bad index answer from the decode
// state; a miss that fits answers from the fit check. Each eviction adds a victim
// scan over n = min(entry_count, ENTRIES) entries, bounded by the single read
// port of the stamp memory walked one entry per cycle.
// Reset clears flags, pin bits, totals and the use counter; no clearing pass.
// A full result register stalls the sequencer until out_ready frees it.
module pinned_lru_byte_budget_cache_top import plbbc_pkg::*; #(
	parameter int ENTRIES        = DEF_ENTRIES,
	parameter int MAX_SIZE_UNITS = DEF_MAX_SIZE,
	localparam int IDXW = $clog2(ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [BUDGET_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [IDXW-1:0]      entry_index,
	input  logic [SIZE_IN_W-1:0] size_units,
	input  logic                 hot,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           status,
	output logic [IDXW-1:0]      slot_index,
	output logic [BUDGET_W-1:0]  resident_units,
	output logic [BUDGET_W-1:0]  pinned_units,
	output logic                 last
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: decode, fit check, LRU scan, eviction loop
	plbbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stores, totals, victim compare and result word register
	plbbc_dp #(
		.ENTRIES        (ENTRIES),
		.MAX_SIZE_UNITS (MAX_SIZE_UNITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.entry_index    (entry_index),
		.size_units     (size_units),
		.hot            (hot),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot_index     (slot_index),
		.resident_units (resident_units),
		.pinned_units   (pinned_units),
		.last           (last)
	);

endmodule
